FILE: rtl/alr_pkg.sv
// alr_pkg: shared constants and helpers for the antialiased line rasterizer.
// No dependencies; every other file in rtl/ refers to it by scoped names.
package alr_pkg;

   // Default geometry: screen coordinate bits and fraction bits of the slope.
   localparam int COORD_BITS_DEF = 11;
   localparam int FRAC_BITS_DEF  = 16;

   // Depth of the command queue between front and back.
   localparam int QUEUE_DEPTH = 2;

   // Request action codes.
   localparam logic ACT_START = 1'b0;
   localparam logic ACT_STEP  = 1'b1;

   // Command kinds carried through the queue.
   localparam logic KIND_SETUP = 1'b0;
   localparam logic KIND_STEP  = 1'b1;

   // Queue entry: {kind, swap, major start, major end, minor start, slope}.
   function automatic int entry_bits(int coord_bits, int frac_bits);
      return 2 + 4 * coord_bits + frac_bits;
   endfunction

endpackage

FILE: rtl/alr_if.sv
// alr_if: request and response channel interfaces (valid/ready plus payload).
// Depends on alr_pkg for default widths.
interface alr_req_if #(
   parameter int COORD_BITS = alr_pkg::COORD_BITS_DEF
);
   logic                  valid;
   logic                  ready;
   logic                  action;
   logic [COORD_BITS-1:0] x_start;
   logic [COORD_BITS-1:0] y_start;
   logic [COORD_BITS-1:0] x_end;
   logic [COORD_BITS-1:0] y_end;

   modport source (output valid, action, x_start, y_start, x_end, y_end, input ready);
   modport sink   (input valid, action, x_start, y_start, x_end, y_end, output ready);
endinterface

interface alr_rsp_if #(
   parameter int COORD_BITS = alr_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = alr_pkg::FRAC_BITS_DEF
);
   logic                valid;
   logic                ready;
   logic [COORD_BITS:0] pixel_x;
   logic [COORD_BITS:0] pixel_y;
   logic [FRAC_BITS:0]  intensity;
   logic                run_last;
   logic                line_done;

   modport source (output valid, pixel_x, pixel_y, intensity, run_last, line_done,
                   input ready);
   modport sink   (input valid, pixel_x, pixel_y, intensity, run_last, line_done,
                   output ready);
endinterface

FILE: rtl/antialiased_line_rasterizer.sv
// Antialiased line rasterizer, top level: front (classify, slope divide),
// command queue and back (pixel walk). Depends on alr_pkg, alr_if and submodules.
// Order: a step's floor pixel passes the queue and output registers, then the adjacent one.
// Throughput: one pixel per cycle unless the port stalls; a new step waits for the last one.
// A start request holds the front until the bit-serial divider is done and the queue takes it.
// Reset: synchronous, active high; clears control state, no clearing pass.
module antialiased_line_rasterizer #(
   parameter int COORD_BITS = alr_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = alr_pkg::FRAC_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   alr_req_if.sink   req_chan,
   alr_rsp_if.source rsp_chan
);
   localparam int E = alr_pkg::entry_bits(COORD_BITS, FRAC_BITS);

   // front -> queue
   logic         fq_valid, fq_ready;
   logic [E-1:0] fq_data;
   // queue -> back
   logic         qb_valid, qb_ready;
   logic [E-1:0] qb_data;

   // Front: takes every request; a start runs the slope division before it
   // hands a setup command to the queue, a step passes straight through.
   alr_front #(
      .COORD_BITS(COORD_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req_chan),
      .q_valid(fq_valid),
      .q_ready(fq_ready),
      .q_data (fq_data)
   );

   // Queue decouples the divider from the pixel walk.
   alr_queue #(
      .WIDTH(E)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .in_valid (fq_valid),
      .in_ready (fq_ready),
      .in_data  (fq_data),
      .out_valid(qb_valid),
      .out_ready(qb_ready),
      .out_data (qb_data)
   );

   // Back: loads line state on setup, emits floor and adjacent pixel per step,
   // drops steps while no line is active.
   alr_back #(
      .COORD_BITS(COORD_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock  (clock),
      .reset  (reset),
      .q_valid(qb_valid),
      .q_ready(qb_ready),
      .q_data (qb_data),
      .rsp    (rsp_chan)
   );

endmodule

FILE: rtl/alr_front.sv
// alr_front: accepts requests, classifies start/step, runs the slope divider.
// Depends on alr_pkg and alr_req_if; feeds alr_queue.
module alr_front #(
   parameter int COORD_BITS = alr_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = alr_pkg::FRAC_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   alr_req_if.sink req,
   output logic q_valid,
   input  logic q_ready,
   output logic [alr_pkg::entry_bits(COORD_BITS, FRAC_BITS)-1:0] q_data
);
   localparam int C        = COORD_BITS;
   localparam int F        = FRAC_BITS;
   localparam int W        = C + F;
   localparam int E        = alr_pkg::entry_bits(C, F);
   localparam int CNT_BITS = $clog2(W + 1);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_DIV  = 1'b1;

   logic state_ff, state_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic swap_ff, swap_in, neg_ff, neg_in;
   logic [C-1:0] maj0_ff, maj0_in, maj1_ff, maj1_in, min0_ff, min0_in, dx_ff, dx_in;
   logic [W-1:0] dvd_ff, dvd_in, quo_ff, quo_in;
   logic [C-1:0] rem_ff, rem_in;

   logic [C-1:0] spanx, spany, a0, b0, a1, b1, maj0, maj1, min0, min1, mag;
   logic         steep, flip;
   logic         accept, start_acc, step_acc, div_done;
   logic [C:0]   rem_sh;
   logic [C-1:0] rem_diff;
   logic         ge;
   logic [W-1:0] slope_val;

   // classify endpoints
   always_comb begin
      spanx = (req.x_end >= req.x_start) ? req.x_end - req.x_start : req.x_start - req.x_end;
      spany = (req.y_end >= req.y_start) ? req.y_end - req.y_start : req.y_start - req.y_end;
      steep = spany > spanx;
      a0 = steep ? req.y_start : req.x_start;
      b0 = steep ? req.x_start : req.y_start;
      a1 = steep ? req.y_end   : req.x_end;
      b1 = steep ? req.x_end   : req.y_end;
      flip = a0 > a1;
      maj0 = flip ? a1 : a0;
      maj1 = flip ? a0 : a1;
      min0 = flip ? b1 : b0;
      min1 = flip ? b0 : b1;
      mag  = (min1 < min0) ? min0 - min1 : min1 - min0;
   end

   assign req.ready = (state_ff == ST_IDLE) && q_ready;
   assign accept    = req.valid && req.ready;
   assign start_acc = accept && (req.action == alr_pkg::ACT_START);
   assign step_acc  = accept && (req.action == alr_pkg::ACT_STEP);
   assign div_done  = (state_ff == ST_DIV) && (cnt_ff == '0);

   // one quotient bit per cycle, restoring; the remainder stays below dx
   assign rem_sh   = {rem_ff, dvd_ff[W-1]};
   assign ge       = rem_sh >= {1'b0, dx_ff};
   assign rem_diff = rem_sh[C-1:0] - dx_ff;
   assign slope_val = (dx_ff == '0) ? '0 : (neg_ff ? W'(0) - quo_ff : quo_ff);

   assign q_valid = div_done || step_acc;
   assign q_data  = div_done ? {alr_pkg::KIND_SETUP, swap_ff, maj0_ff, maj1_ff, min0_ff,
                                slope_val}
                             : {alr_pkg::KIND_STEP, (E-1)'(0)};

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      swap_in  = swap_ff;
      neg_in   = neg_ff;
      maj0_in  = maj0_ff;
      maj1_in  = maj1_ff;
      min0_in  = min0_ff;
      dx_in    = dx_ff;
      dvd_in   = dvd_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start_acc) begin
               state_in = ST_DIV;
               cnt_in   = CNT_BITS'(W);
               swap_in  = steep;
               neg_in   = min1 < min0;
               maj0_in  = maj0;
               maj1_in  = maj1;
               min0_in  = min0;
               dx_in    = maj1 - maj0;
               dvd_in   = {mag, {F{1'b0}}};
               quo_in   = '0;
               rem_in   = '0;
            end
         end
         ST_DIV: begin
            if (cnt_ff != '0) begin
               cnt_in = cnt_ff - 1'b1;
               dvd_in = {dvd_ff[W-2:0], 1'b0};
               quo_in = {quo_ff[W-2:0], ge};
               rem_in = ge ? rem_diff : rem_sh[C-1:0];
            end else if (q_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      swap_ff <= swap_in;
      neg_ff  <= neg_in;
      maj0_ff <= maj0_in;
      maj1_ff <= maj1_in;
      min0_ff <= min0_in;
      dx_ff   <= dx_in;
      dvd_ff  <= dvd_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
   end

endmodule

FILE: rtl/alr_queue.sv
// alr_queue: short command FIFO between front and back.
// Depends on alr_pkg for its depth.
module alr_queue #(
   parameter int WIDTH = alr_pkg::entry_bits(alr_pkg::COORD_BITS_DEF, alr_pkg::FRAC_BITS_DEF)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);
   localparam int DEPTH    = alr_pkg::QUEUE_DEPTH;
   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    mem_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                push, pop;

   assign in_ready  = cnt_ff != CNT_BITS'(DEPTH);
   assign out_valid = cnt_ff != '0;
   assign out_data  = mem_ff[rd_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) wr_in = (wr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      if (pop)  rd_in = (rd_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      if (push && !pop) cnt_in = cnt_ff + 1'b1;
      else if (pop && !push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= in_data;
   end

endmodule

FILE: rtl/alr_back.sv
// alr_back: holds line state, walks the major axis and emits pixel pairs.
// Depends on alr_pkg and alr_rsp_if; drains alr_queue.
module alr_back #(
   parameter int COORD_BITS = alr_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = alr_pkg::FRAC_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic q_valid,
   output logic q_ready,
   input  logic [alr_pkg::entry_bits(COORD_BITS, FRAC_BITS)-1:0] q_data,
   alr_rsp_if.source rsp
);
   localparam int C = COORD_BITS;
   localparam int F = FRAC_BITS;
   localparam int W = C + F;
   localparam int E = alr_pkg::entry_bits(C, F);
   localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

   // entry fields
   logic         e_kind, e_swap;
   logic [C-1:0] e_maj0, e_maj1, e_min0;
   logic [W-1:0] e_slope;

   assign e_kind  = q_data[E-1];
   assign e_swap  = q_data[E-2];
   assign e_maj0  = q_data[E-3 -: C];
   assign e_maj1  = q_data[E-3-C -: C];
   assign e_min0  = q_data[E-3-2*C -: C];
   assign e_slope = q_data[W-1:0];

   logic         active_ff, active_in, busy_ff, busy_in, swap_ff, swap_in;
   logic [C-1:0] pos_ff, pos_in, end_ff, end_in;
   logic [W-1:0] acc_ff, acc_in, slope_ff, slope_in;

   logic         out_valid_ff, out_valid_in, last_ff, last_in, done_ff, done_in;
   logic [C:0]   px_ff, px_in, py_ff, py_in;
   logic [F:0]   int_ff, int_in;

   logic         out_free, can_pop, pop, emit0, emit1, last_col;
   logic [C:0]   major, minor_lo, minor_hi;
   logic [F-1:0] frac;

   assign out_free = !out_valid_ff || rsp.ready;
   assign can_pop  = !busy_ff && ((e_kind == alr_pkg::KIND_SETUP) || !active_ff || out_free);
   assign q_ready  = can_pop;
   assign pop      = q_valid && can_pop;
   assign emit0    = pop && (e_kind == alr_pkg::KIND_STEP) && active_ff;
   assign emit1    = busy_ff && out_free;
   assign last_col = pos_ff == end_ff;

   assign major    = {1'b0, pos_ff};
   assign minor_lo = {1'b0, acc_ff[W-1:F]};
   assign minor_hi = minor_lo + 1'b1;
   assign frac     = acc_ff[F-1:0];

   always_comb begin
      active_in    = active_ff;
      busy_in      = busy_ff;
      swap_in      = swap_ff;
      pos_in       = pos_ff;
      end_in       = end_ff;
      acc_in       = acc_ff;
      slope_in     = slope_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      px_in        = px_ff;
      py_in        = py_ff;
      int_in       = int_ff;
      last_in      = last_ff;
      done_in      = done_ff;
      if (pop && (e_kind == alr_pkg::KIND_SETUP)) begin
         active_in = 1'b1;
         swap_in   = e_swap;
         pos_in    = e_maj0;
         end_in    = e_maj1;
         acc_in    = {e_min0, {F{1'b0}}};
         slope_in  = e_slope;
      end
      if (emit0) begin
         busy_in      = 1'b1;
         out_valid_in = 1'b1;
         px_in        = swap_ff ? minor_lo : major;
         py_in        = swap_ff ? major : minor_lo;
         int_in       = ONE - {1'b0, frac};
         last_in      = 1'b0;
         done_in      = 1'b0;
      end
      if (emit1) begin
         busy_in      = 1'b0;
         out_valid_in = 1'b1;
         px_in        = swap_ff ? minor_hi : major;
         py_in        = swap_ff ? major : minor_hi;
         int_in       = {1'b0, frac};
         last_in      = 1'b1;
         done_in      = last_col;
         if (last_col) begin
            active_in = 1'b0;
         end else begin
            pos_in = pos_ff + 1'b1;
            acc_in = acc_ff + slope_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      swap_ff  <= swap_in;
      pos_ff   <= pos_in;
      end_ff   <= end_in;
      acc_ff   <= acc_in;
      slope_ff <= slope_in;
      px_ff    <= px_in;
      py_ff    <= py_in;
      int_ff   <= int_in;
      last_ff  <= last_in;
      done_ff  <= done_in;
   end

   assign rsp.valid     = out_valid_ff;
   assign rsp.pixel_x   = px_ff;
   assign rsp.pixel_y   = py_ff;
   assign rsp.intensity = int_ff;
   assign rsp.run_last  = last_ff;
   assign rsp.line_done = done_ff;

`ifndef ASSERT_OFF
   a_busy_needs_line: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> active_ff)
      else $error("step in progress without an active line");
   a_first_then_second: assert property (@(posedge clock) disable iff (reset)
      emit0 |=> busy_ff)
      else $error("floor pixel not followed by adjacent pixel");
   a_last_col_ends: assert property (@(posedge clock) disable iff (reset)
      (emit1 && last_col) |=> !active_ff)
      else $error("line still active after its last column");
   a_done_on_adjacent: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && done_ff) |-> last_ff)
      else $error("line_done on a floor pixel");
`endif

endmodule
